// ===== hw/rtl/chsd_pkg.sv =====
`default_nettype none
package chsd_pkg;

  localparam int unsigned WordW = 9;
  localparam int unsigned CodeW = 64;
  localparam int unsigned IdxW = 16;
  localparam int unsigned CountSumW = 10;

  localparam logic [WordW-1:0] SymNameEnd = 9'd256;
  localparam logic [WordW-1:0] SymNextFile = 9'd257;
  localparam logic [WordW-1:0] SymArchiveEnd = 9'd258;

  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_DATA     = 3'd1,
    KIND_NAME_END = 3'd2,
    KIND_NEXT     = 3'd3,
    KIND_END      = 3'd4,
    KIND_ERR      = 3'd5
  } kind_e;

  typedef struct packed {
    logic             func;
    logic [WordW-1:0] word;
    logic             bit_req;
  } item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chsd_if.sv =====
`default_nettype none
interface chsd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [8:0] word;
  logic       bit_req;
  modport source (output valid, func, word, bit_req, input ready);
  modport sink (input valid, func, word, bit_req, output ready);
endinterface

interface chsd_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] symbol;
  logic [2:0] kind;
  modport source (output valid, symbol, kind, input ready);
  modport sink (input valid, symbol, kind, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/chsd_front.sv =====
`default_nettype none
module chsd_front import chsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chsd_in_if.sink   in_i,
  output item_t     item_o,
  output logic      item_valid_o,
  input  wire logic item_ready_i
);

  item_t      buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_i.ready   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rptr_q];
  assign push         = in_i.valid && in_i.ready;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= '{func: in_i.func, word: in_i.word, bit_req: in_i.bit_req};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/chsd_back.sv =====
`default_nettype none
module chsd_back import chsd_pkg::*; #(
  parameter int unsigned ALPHABET = 259,
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  item_t     item_i,
  input  wire logic item_valid_i,
  output logic      item_ready_o,
  chsd_out_if.source out_o
);

  localparam int unsigned SW  = $clog2(ALPHABET + 1);
  localparam int unsigned AW  = $clog2(ALPHABET);
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  localparam int unsigned LIW = $clog2(MAX_LEN);
  localparam logic [CountSumW-1:0] AlphaV = CountSumW'(ALPHABET);
  localparam logic [LW-1:0] MaxLenV = LW'(MAX_LEN);

  typedef enum logic [1:0] {
    PH_COUNT, PH_SYMBOLS, PH_LENGTHS, PH_DECODE
  } phase_e;

  phase_e               ph_q, ph_d;
  logic [SW-1:0]        total_q, total_d, sload_q, sload_d;
  logic [WordW-1:0]     lcnt_q [MAX_LEN];
  logic [WordW-1:0]     lcnt_d [MAX_LEN];
  logic [LW-1:0]        lload_q, lload_d, plen_q, plen_d;
  logic [CountSumW-1:0] cc_q, cc_d;
  logic [CodeW-1:0]     pcode_q, pcode_d, fcode_q, fcode_d;
  logic [IdxW-1:0]      fidx_q, fidx_d;
  logic                 in_name_q, in_name_d, pend_q, pend_d;
  logic                 ov_q, ov_d;
  logic [WordW-1:0]     osym_q, osym_d;
  kind_e                okind_q, okind_d;

  logic [WordW-1:0]     store [ALPHABET];
  logic [WordW-1:0]     rd_q;
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;

  logic                 slot_free, take;
  logic [CountSumW-1:0] wext, cc_sum;
  logic [SW-1:0]        sload_inc;
  logic [LW-1:0]        lload_inc, pl;
  logic [CodeW-1:0]     pc, off;
  logic [WordW-1:0]     cnt;
  logic [IdxW-1:0]      idx;

  assign slot_free    = !ov_q || out_o.ready;
  assign item_ready_o = !pend_q && slot_free;
  assign take         = item_valid_i && item_ready_o;
  assign out_o.valid  = ov_q;
  assign out_o.symbol = osym_q;
  assign out_o.kind   = okind_q;

  assign wext      = CountSumW'(item_i.word);
  assign cc_sum    = cc_q + wext;
  assign sload_inc = sload_q + SW'(1);
  assign lload_inc = lload_q + LW'(1);
  assign pc        = {pcode_q[CodeW-2:0], item_i.bit_req};
  assign pl        = plen_q + LW'(1);
  assign cnt       = lcnt_q[plen_q[LIW-1:0]];
  assign off       = pc - fcode_q;
  assign idx       = fidx_q + off[IdxW-1:0];

  always_comb begin
    ph_d      = ph_q;
    total_d   = total_q;
    sload_d   = sload_q;
    lcnt_d    = lcnt_q;
    lload_d   = lload_q;
    cc_d      = cc_q;
    pcode_d   = pcode_q;
    plen_d    = plen_q;
    fcode_d   = fcode_q;
    fidx_d    = fidx_q;
    in_name_d = in_name_q;
    pend_d    = pend_q;
    ov_d      = ov_q && !out_o.ready;
    osym_d    = osym_q;
    okind_d   = okind_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = sload_q[AW-1:0];
    raddr     = idx[AW-1:0];
    if (pend_q) begin
      if (slot_free) begin
        pend_d = 1'b0;
        ov_d   = 1'b1;
        osym_d = rd_q;
        if (rd_q < SymNameEnd) begin
          okind_d = in_name_q ? KIND_NAME : KIND_DATA;
        end else if (rd_q == SymNameEnd && in_name_q) begin
          in_name_d = 1'b0;
          okind_d   = KIND_NAME_END;
        end else if ((rd_q == SymNextFile || rd_q == SymArchiveEnd) && !in_name_q) begin
          ph_d      = PH_COUNT;
          in_name_d = 1'b1;
          okind_d   = (rd_q == SymNextFile) ? KIND_NEXT : KIND_END;
        end else begin
          okind_d = KIND_ERR;
        end
      end
    end else if (take) begin
      if ((ph_q == PH_DECODE) != item_i.func) begin
        ov_d    = 1'b1;
        osym_d  = '0;
        okind_d = KIND_ERR;
      end else begin
        case (ph_q)
          PH_COUNT: begin
            if (item_i.word == '0 || wext > AlphaV) begin
              ov_d    = 1'b1;
              osym_d  = item_i.word;
              okind_d = KIND_ERR;
            end else begin
              total_d = SW'(item_i.word);
              sload_d = '0;
              lload_d = '0;
              cc_d    = '0;
              for (int i = 0; i < MAX_LEN; i++) lcnt_d[i] = '0;
              ph_d    = PH_SYMBOLS;
            end
          end
          PH_SYMBOLS: begin
            if (wext >= AlphaV) begin
              ph_d    = PH_COUNT;
              ov_d    = 1'b1;
              osym_d  = item_i.word;
              okind_d = KIND_ERR;
            end else begin
              we      = 1'b1;
              sload_d = sload_inc;
              if (sload_inc >= total_q) ph_d = PH_LENGTHS;
            end
          end
          PH_LENGTHS: begin
            lcnt_d[lload_q[LIW-1:0]] = item_i.word;
            lload_d = lload_inc;
            cc_d    = cc_sum;
            if (cc_sum == CountSumW'(total_q)) begin
              ph_d      = PH_DECODE;
              pcode_d   = '0;
              plen_d    = '0;
              fcode_d   = '0;
              fidx_d    = '0;
              in_name_d = 1'b1;
            end else if (cc_sum > CountSumW'(total_q) || lload_inc >= MaxLenV) begin
              ph_d    = PH_COUNT;
              ov_d    = 1'b1;
              osym_d  = item_i.word;
              okind_d = KIND_ERR;
            end
          end
          default: begin
            if (off < CodeW'(cnt)) begin
              pcode_d = '0;
              plen_d  = '0;
              fcode_d = '0;
              fidx_d  = '0;
              if (idx >= IdxW'(ALPHABET)) begin
                ov_d    = 1'b1;
                osym_d  = '0;
                okind_d = KIND_ERR;
              end else begin
                re     = 1'b1;
                pend_d = 1'b1;
              end
            end else if (pl >= MaxLenV) begin
              pcode_d = '0;
              plen_d  = '0;
              fcode_d = '0;
              fidx_d  = '0;
              ov_d    = 1'b1;
              osym_d  = '0;
              okind_d = KIND_ERR;
            end else begin
              pcode_d = pc;
              plen_d  = pl;
              fidx_d  = fidx_q + IdxW'(cnt);
              fcode_d = (fcode_q + CodeW'(cnt)) << 1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_COUNT;
      total_q   <= '0;
      sload_q   <= '0;
      for (int i = 0; i < MAX_LEN; i++) lcnt_q[i] <= '0;
      lload_q   <= '0;
      cc_q      <= '0;
      pcode_q   <= '0;
      plen_q    <= '0;
      fcode_q   <= '0;
      fidx_q    <= '0;
      in_name_q <= 1'b1;
      pend_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      ph_q      <= ph_d;
      total_q   <= total_d;
      sload_q   <= sload_d;
      lcnt_q    <= lcnt_d;
      lload_q   <= lload_d;
      cc_q      <= cc_d;
      pcode_q   <= pcode_d;
      plen_q    <= plen_d;
      fcode_q   <= fcode_d;
      fidx_q    <= fidx_d;
      in_name_q <= in_name_d;
      pend_q    <= pend_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    osym_q  <= osym_d;
    okind_q <= okind_d;
    if (we) store[waddr] <= item_i.word;
    if (re) rd_q <= store[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/canonical_huffman_stream_decoder_core.sv =====
`default_nettype none
// Canonical Huffman archive decoder. Each transaction on in_i is one 9-bit header
// word or one code bit and is taken through a two-entry input queue. Items are
// accepted one item per cycle while the output register is free; a code bit that
// completes a code holds the input until the registered symbol store read is sent
// to the output register on out_o, through which all results leave. The symbol
// store holds no reset value; every entry read was written by the current header.
module canonical_huffman_stream_decoder_core import chsd_pkg::*; #(
  parameter int unsigned ALPHABET = 259,
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chsd_in_if.sink    in_i,
  chsd_out_if.source out_o
);

  item_t item;
  logic  item_valid, item_ready;

  chsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  chsd_back #(
    .ALPHABET (ALPHABET),
    .MAX_LEN  (MAX_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire
